@@ hw/rtl/krdoq_pkg.sv @@
// shared types and constants for the keyframe resync drop-oldest queue
`timescale 1ns / 1ps

package krdoq_pkg;

  localparam int SEQ_W  = 64;
  localparam int LEN_W  = 24;
  localparam int HDL_W  = 16;
  localparam int CEIL_W = 32;
  localparam int CAP_W  = 6;
  localparam int IDX_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd16;

  localparam logic [IDX_W-1:0] CFG_UNIT_CAPACITY = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BYTE_CEILING  = 2'd1;

  localparam logic KIND_ANSWER  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PEEK    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_RESYNC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_LEN = 2'd1,
    STAT_NO_UNIT  = 2'd2
  } status_t;

  // controller to datapath strobes
  typedef struct packed {
    logic    accept;
    logic    pu_start;
    logic    pu_over;
    logic    pu_evict;
    logic    pu_commit;
    logic    pu_write;
    logic    rel_emit;
    logic    rel_sub;
    logic    ad_a;
    logic    ad_b;
    logic    pk_clamp;
    logic    pk_locate;
    logic    pk_step;
    logic    set_resync;
    logic    ans_load;
    status_t ans_status;
  } cmd_t;

  // datapath to controller flags
  typedef struct packed {
    logic len_zero;
    logic over_ceil;
    logic evict_need;
    logic count_zero;
    logic loc_ok;
    logic kf_hit;
    logic rem_last;
    logic n_last;
    logic n_zero;
    logic resync;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/keyframe_resync_drop_oldest_queue.sv @@
// top level: drop-oldest burst queue with byte budget and keyframe resync
//
//   port group  dir   handshake          carries
//   in_*        in    in_valid/in_ready  one request (op and its operands)
//   out_*       out   out_valid/out_ready release notices then one answer
//   cfg_*       in    cfg_we             unit_capacity / byte_ceiling writes
//
// one request at a time; a push steps through each evicted unit, each released unit
// is reported in turn, and a peek during resync scans slot by slot, all paced by
// the single registered slot memory read port
// reset is synchronous active low and empties the queue; a config write to
// unit_capacity or byte_ceiling does too; a stalled out_ready holds the sequencer before each result
`timescale 1ns / 1ps

module keyframe_resync_drop_oldest_queue #(
  parameter int MAX_UNITS   = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_handle,
  input  logic [23:0] in_burst_length,
  input  logic        in_is_keyframe,
  input  logic [63:0] in_cursor,
  input  logic [63:0] in_accepted_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_unit_handle,
  output logic [23:0] out_unit_length,
  output logic [63:0] out_unit_sequence,
  output logic        out_unit_keyframe,
  output logic [63:0] out_cursor_next,
  output logic [63:0] out_head_count,
  output logic [63:0] out_dropped_count,
  output logic [63:0] out_pushed_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = $clog2(MAX_UNITS + 1);

  krdoq_pkg::cmd_t cmd;
  krdoq_pkg::sts_t sts;

  // configuration registers
  logic [krdoq_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic [krdoq_pkg::CEIL_W-1:0] ceil_r, ceil_nxt;
  logic                         clear;
  logic [CW-1:0]                cap_eff;

  // any write to a known register empties the queue
  always_comb begin
    cap_nxt  = cap_r;
    ceil_nxt = ceil_r;
    clear    = 1'b0;
    if (cfg_we) begin
      if (cfg_index == krdoq_pkg::CFG_UNIT_CAPACITY) begin
        cap_nxt = cfg_data[krdoq_pkg::CAP_W-1:0];
        clear   = 1'b1;
      end else if (cfg_index == krdoq_pkg::CFG_BYTE_CEILING) begin
        ceil_nxt = cfg_data;
        clear    = 1'b1;
      end
    end
  end

  // zero or too large means the built maximum
  assign cap_eff = ((cap_r == '0) || (cap_r > krdoq_pkg::CAP_W'(MAX_UNITS)))
                 ? CW'(MAX_UNITS) : CW'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= krdoq_pkg::CAP_RESET;
      ceil_r <= '0;
    end else begin
      cap_r  <= cap_nxt;
      ceil_r <= ceil_nxt;
    end
  end

  krdoq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  krdoq_dpath #(
    .MAX_UNITS   (MAX_UNITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .clear_i              (clear),
    .cap_i                (cap_eff),
    .ceil_i               (ceil_r),
    .in_op                (in_op),
    .in_handle            (in_handle),
    .in_burst_length      (in_burst_length),
    .in_is_keyframe       (in_is_keyframe),
    .in_cursor            (in_cursor),
    .in_accepted_sequence (in_accepted_sequence),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_status           (out_status),
    .out_unit_handle      (out_unit_handle),
    .out_unit_length      (out_unit_length),
    .out_unit_sequence    (out_unit_sequence),
    .out_unit_keyframe    (out_unit_keyframe),
    .out_cursor_next      (out_cursor_next),
    .out_head_count       (out_head_count),
    .out_dropped_count    (out_dropped_count),
    .out_pushed_count     (out_pushed_count),
    .out_last             (out_last)
  );

endmodule

@@ hw/rtl/krdoq_ctrl.sv @@
// sequencing state machine for the queue operations
`timescale 1ns / 1ps

module krdoq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  input  krdoq_pkg::sts_t    sts_i,
  output krdoq_pkg::cmd_t    cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_PU_A     = 17'h00002,
    S_PU_TEST  = 17'h00004,
    S_PU_SUB   = 17'h00008,
    S_PU_CNT   = 17'h00010,
    S_REL_WAIT = 17'h00020,
    S_REL_EMIT = 17'h00040,
    S_PU_WR    = 17'h00080,
    S_AD_A     = 17'h00100,
    S_AD_B     = 17'h00200,
    S_AD_C     = 17'h00400,
    S_PK_A     = 17'h00800,
    S_PK_B     = 17'h01000,
    S_PK_C     = 17'h02000,
    S_PK_D     = 17'h04000,
    S_RS       = 17'h08000,
    S_ANS      = 17'h10000
  } state_t;

  state_t                state_r, state_nxt;
  krdoq_pkg::op_t        op_r, op_nxt;
  krdoq_pkg::status_t    ans_r, ans_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ans_nxt   = ans_r;
    cmd_o     = '0;
    cmd_o.ans_status = ans_r;
    cmd_o.rel_sub    = (op_r == krdoq_pkg::OP_ADVANCE);
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          op_nxt  = krdoq_pkg::op_t'(in_op);
          ans_nxt = krdoq_pkg::STAT_OK;
          unique case (krdoq_pkg::op_t'(in_op))
            krdoq_pkg::OP_PUSH:    state_nxt = S_PU_A;
            krdoq_pkg::OP_PEEK:    state_nxt = S_PK_A;
            krdoq_pkg::OP_ADVANCE: state_nxt = S_AD_A;
            krdoq_pkg::OP_RESYNC:  state_nxt = S_RS;
          endcase
        end
      end
      S_PU_A: begin
        if (sts_i.len_zero) begin
          ans_nxt   = krdoq_pkg::STAT_ZERO_LEN;
          state_nxt = S_ANS;
        end else if (sts_i.over_ceil) begin
          cmd_o.pu_over = 1'b1;
          state_nxt = S_ANS;
        end else begin
          cmd_o.pu_start = 1'b1;
          state_nxt = S_PU_TEST;
        end
      end
      S_PU_TEST: begin
        if (sts_i.evict_need) begin
          state_nxt = S_PU_SUB;
        end else begin
          cmd_o.pu_commit = 1'b1;
          state_nxt = sts_i.n_zero ? S_PU_WR : S_REL_WAIT;
        end
      end
      S_PU_SUB: begin
        cmd_o.pu_evict = 1'b1;
        state_nxt = S_PU_TEST;
      end
      S_REL_WAIT: state_nxt = S_REL_EMIT;
      S_REL_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.rel_emit = 1'b1;
          if (sts_i.n_last) begin
            state_nxt = (op_r == krdoq_pkg::OP_PUSH) ? S_PU_WR : S_ANS;
          end else begin
            state_nxt = S_REL_WAIT;
          end
        end
      end
      S_PU_WR: begin
        cmd_o.pu_write = 1'b1;
        state_nxt = S_ANS;
      end
      S_AD_A: begin
        cmd_o.ad_a = 1'b1;
        state_nxt = S_AD_B;
      end
      S_AD_B: begin
        cmd_o.ad_b = 1'b1;
        state_nxt = S_AD_C;
      end
      S_AD_C: state_nxt = sts_i.n_zero ? S_ANS : S_REL_WAIT;
      S_PK_A: begin
        if (sts_i.count_zero) begin
          ans_nxt   = krdoq_pkg::STAT_NO_UNIT;
          state_nxt = S_ANS;
        end else begin
          cmd_o.pk_clamp = 1'b1;
          state_nxt = S_PK_B;
        end
      end
      S_PK_B: begin
        cmd_o.pk_locate = 1'b1;
        state_nxt = S_PK_C;
      end
      S_PK_C: begin
        if (!sts_i.loc_ok) begin
          ans_nxt   = krdoq_pkg::STAT_NO_UNIT;
          state_nxt = S_ANS;
        end else begin
          state_nxt = S_PK_D;
        end
      end
      S_PK_D: begin
        if (!sts_i.resync || sts_i.kf_hit) begin
          state_nxt = S_ANS;
        end else if (sts_i.rem_last) begin
          ans_nxt   = krdoq_pkg::STAT_NO_UNIT;
          state_nxt = S_ANS;
        end else begin
          cmd_o.pk_step = 1'b1;
          state_nxt = S_PK_C;
        end
      end
      S_RS: begin
        cmd_o.set_resync = 1'b1;
        state_nxt = S_ANS;
      end
      S_ANS: begin
        if (sts_i.out_free) begin
          cmd_o.ans_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ans_r <= ans_nxt;
  end

`ifndef SYNTHESIS
  a_ans_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ANS && sts_i.out_free) |=> (state_r == S_IDLE))
    else $error("answer sent but controller not idle");
`endif

endmodule

@@ hw/rtl/krdoq_dpath.sv @@
// queue datapath: slot memory, sequence counters, byte budget, result register
`timescale 1ns / 1ps

module krdoq_dpath #(
  parameter int MAX_UNITS   = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  krdoq_pkg::cmd_t          cmd_i,
  output krdoq_pkg::sts_t          sts_o,
  input  logic                     clear_i,
  input  logic [$clog2(MAX_UNITS+1)-1:0] cap_i,
  input  logic [krdoq_pkg::CEIL_W-1:0]   ceil_i,
  input  logic [1:0]               in_op,
  input  logic [krdoq_pkg::HDL_W-1:0] in_handle,
  input  logic [krdoq_pkg::LEN_W-1:0] in_burst_length,
  input  logic                     in_is_keyframe,
  input  logic [krdoq_pkg::SEQ_W-1:0] in_cursor,
  input  logic [krdoq_pkg::SEQ_W-1:0] in_accepted_sequence,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic [1:0]               out_status,
  output logic [krdoq_pkg::HDL_W-1:0] out_unit_handle,
  output logic [krdoq_pkg::LEN_W-1:0] out_unit_length,
  output logic [krdoq_pkg::SEQ_W-1:0] out_unit_sequence,
  output logic                     out_unit_keyframe,
  output logic [krdoq_pkg::SEQ_W-1:0] out_cursor_next,
  output logic [krdoq_pkg::SEQ_W-1:0] out_head_count,
  output logic [krdoq_pkg::SEQ_W-1:0] out_dropped_count,
  output logic [krdoq_pkg::SEQ_W-1:0] out_pushed_count,
  output logic                     out_last
);

  localparam int SW  = $clog2(MAX_UNITS);
  localparam int CW  = $clog2(MAX_UNITS + 1);
  localparam int HB  = (HANDLE_BITS < krdoq_pkg::HDL_W) ? HANDLE_BITS : krdoq_pkg::HDL_W;
  localparam int QW  = krdoq_pkg::SEQ_W;
  localparam int LW  = krdoq_pkg::LEN_W;
  localparam int BW  = krdoq_pkg::CEIL_W;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] idx,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx = CW'(idx) + CW'(1);
    return (nx == cap) ? '0 : nx[SW-1:0];
  endfunction

  function automatic logic [BW-1:0] sat_sub(input logic [BW-1:0] a,
                                            input logic [LW-1:0] b);
    return (BW'(b) > a) ? '0 : (a - BW'(b));
  endfunction

  // slot memory
  logic [HB-1:0] mem_hdl [MAX_UNITS];
  logic [LW-1:0] mem_len [MAX_UNITS];
  logic          mem_kf  [MAX_UNITS];
  logic [HB-1:0] rd_hdl_r;
  logic [LW-1:0] rd_len_r;
  logic          rd_kf_r;

  // captured request
  krdoq_pkg::op_t op_r, op_nxt;
  logic [HB-1:0]  hdl_r, hdl_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           kfin_r, kfin_nxt;
  logic [QW-1:0]  cursor_r, cursor_nxt;
  logic [QW-1:0]  acc_r, acc_nxt;

  // queue state
  logic [QW-1:0]  head_r, head_nxt;
  logic [QW-1:0]  tail_r, tail_nxt;
  logic [SW-1:0]  head_slot_r, head_slot_nxt;
  logic [SW-1:0]  tail_slot_r, tail_slot_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [BW-1:0]  retained_r, retained_nxt;
  logic [QW-1:0]  drop_r, drop_nxt;
  logic [QW-1:0]  push_r, push_nxt;
  logic           resync_r, resync_nxt;

  // working registers
  logic [SW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  wcnt_r, wcnt_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  s_r, s_nxt;
  logic [QW-1:0]  next_r, next_nxt;
  logic [QW-1:0]  diff_r, diff_nxt;
  logic           dcond_r, dcond_nxt;
  logic           loc_ok_r, loc_ok_nxt;

  // result register
  logic           ov_r, ov_nxt;
  logic           ok_r, ok_nxt;
  logic [1:0]     ost_r, ost_nxt;
  logic [LW-1:0]  olen_r, olen_nxt;
  logic [HB-1:0]  ohdl_r, ohdl_nxt;
  logic [QW-1:0]  oseq_r, oseq_nxt;
  logic           okf_r, okf_nxt;
  logic [QW-1:0]  ocur_r, ocur_nxt;
  logic [QW-1:0]  ohead_r, ohead_nxt;
  logic [QW-1:0]  odrop_r, odrop_nxt;
  logic [QW-1:0]  opush_r, opush_nxt;
  logic           olast_r, olast_nxt;

  logic [BW:0]    fit_sum;
  logic [BW:0]    add_sum;
  logic [QW:0]    adv_diff;
  logic [QW-1:0]  pk_off;
  logic [CW:0]    pk_sum;
  logic           out_free;
  logic           show_unit;

  assign out_free = !ov_r || out_ready;
  assign fit_sum  = {1'b0, retained_r} + (BW + 1)'(len_r);
  assign add_sum  = fit_sum;
  assign adv_diff = {1'b0, next_r} - {1'b0, tail_r};
  assign pk_off   = s_r - tail_r;
  assign pk_sum   = (CW + 1)'(tail_slot_r) + (CW + 1)'(pk_off[CW-1:0]);
  assign show_unit = (op_r == krdoq_pkg::OP_PEEK) && (cmd_i.ans_status == krdoq_pkg::STAT_OK);

  always_comb begin
    sts_o.len_zero   = (len_r == '0);
    sts_o.over_ceil  = (ceil_i != '0) && (BW'(len_r) > ceil_i);
    sts_o.evict_need = (wcnt_r != '0) &&
                       ((wcnt_r >= cap_i) ||
                        ((ceil_i != '0) && (fit_sum > (BW + 1)'(ceil_i))));
    sts_o.count_zero = (count_r == '0);
    sts_o.loc_ok     = loc_ok_r;
    sts_o.kf_hit     = rd_kf_r;
    sts_o.rem_last   = (rem_r == CW'(1));
    sts_o.n_last     = (n_r == CW'(1));
    sts_o.n_zero     = (n_r == '0);
    sts_o.resync     = resync_r;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    op_nxt = op_r; hdl_nxt = hdl_r; len_nxt = len_r; kfin_nxt = kfin_r;
    cursor_nxt = cursor_r; acc_nxt = acc_r;
    head_nxt = head_r; tail_nxt = tail_r; head_slot_nxt = head_slot_r;
    tail_slot_nxt = tail_slot_r; count_nxt = count_r; retained_nxt = retained_r;
    drop_nxt = drop_r; push_nxt = push_r; resync_nxt = resync_r;
    ptr_nxt = ptr_r; n_nxt = n_r; wcnt_nxt = wcnt_r; rem_nxt = rem_r; s_nxt = s_r;
    next_nxt = next_r; diff_nxt = diff_r; dcond_nxt = dcond_r; loc_ok_nxt = loc_ok_r;
    ov_nxt = ov_r; ok_nxt = ok_r; ost_nxt = ost_r; olen_nxt = olen_r; ohdl_nxt = ohdl_r;
    oseq_nxt = oseq_r; okf_nxt = okf_r; ocur_nxt = ocur_r; ohead_nxt = ohead_r;
    odrop_nxt = odrop_r; opush_nxt = opush_r; olast_nxt = olast_r;

    if (cmd_i.accept) begin
      op_nxt     = krdoq_pkg::op_t'(in_op);
      hdl_nxt    = in_handle[HB-1:0];
      len_nxt    = in_burst_length;
      kfin_nxt   = in_is_keyframe;
      cursor_nxt = in_cursor;
      acc_nxt    = in_accepted_sequence;
    end

    // oversized burst never enters the ring
    if (cmd_i.pu_over) begin
      drop_nxt   = drop_r + QW'(1);
      resync_nxt = 1'b1;
    end

    // first pass: count evictions and settle the byte budget
    if (cmd_i.pu_start) begin
      ptr_nxt  = tail_slot_r;
      n_nxt    = '0;
      wcnt_nxt = count_r;
    end
    if (cmd_i.pu_evict) begin
      retained_nxt = sat_sub(retained_r, rd_len_r);
      wcnt_nxt     = wcnt_r - CW'(1);
      n_nxt        = n_r + CW'(1);
      ptr_nxt      = slot_inc(ptr_r, cap_i);
    end
    if (cmd_i.pu_commit) begin
      head_nxt = head_r + QW'(1);
      push_nxt = push_r + QW'(1);
      drop_nxt = drop_r + QW'(n_r);
      if (n_r != '0) resync_nxt = 1'b1;
      ptr_nxt  = tail_slot_r;
    end
    if (cmd_i.pu_write) begin
      retained_nxt  = add_sum[BW] ? '1 : add_sum[BW-1:0];
      head_slot_nxt = slot_inc(head_slot_r, cap_i);
      count_nxt     = count_r + CW'(1);
    end

    // second pass: report released units oldest first
    if (cmd_i.rel_emit) begin
      tail_nxt      = tail_r + QW'(1);
      tail_slot_nxt = slot_inc(tail_slot_r, cap_i);
      ptr_nxt       = slot_inc(tail_slot_r, cap_i);
      count_nxt     = count_r - CW'(1);
      n_nxt         = n_r - CW'(1);
      if (cmd_i.rel_sub) retained_nxt = sat_sub(retained_r, rd_len_r);
    end

    if (cmd_i.ad_a) begin
      next_nxt  = acc_r + QW'(1);
      dcond_nxt = resync_r && (acc_r >= tail_r);
      diff_nxt  = acc_r - tail_r;
    end
    if (cmd_i.ad_b) begin
      if (dcond_r) begin
        drop_nxt   = drop_r + diff_r;
        resync_nxt = 1'b0;
      end
      ptr_nxt = tail_slot_r;
      if (adv_diff[QW] || (adv_diff[QW-1:0] == '0)) begin
        n_nxt = '0;
      end else if ((adv_diff[QW-1:CW] != '0) || (adv_diff[CW-1:0] >= count_r)) begin
        n_nxt = count_r;
      end else begin
        n_nxt = adv_diff[CW-1:0];
      end
    end

    if (cmd_i.pk_clamp) begin
      s_nxt = (cursor_r < tail_r) ? tail_r : cursor_r;
    end
    if (cmd_i.pk_locate) begin
      loc_ok_nxt = (pk_off[QW-1:CW] == '0) && (pk_off[CW-1:0] < count_r);
      ptr_nxt    = (pk_sum >= (CW + 1)'(cap_i)) ? SW'(pk_sum - (CW + 1)'(cap_i))
                                                : SW'(pk_sum);
      rem_nxt    = count_r - pk_off[CW-1:0];
    end
    if (cmd_i.pk_step) begin
      s_nxt   = s_r + QW'(1);
      ptr_nxt = slot_inc(ptr_r, cap_i);
      rem_nxt = rem_r - CW'(1);
    end

    if (cmd_i.set_resync) resync_nxt = 1'b1;

    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cmd_i.rel_emit || cmd_i.ans_load) begin
      ov_nxt    = 1'b1;
      ohead_nxt = head_r;
      odrop_nxt = drop_r;
      opush_nxt = push_r;
    end
    if (cmd_i.rel_emit) begin
      ok_nxt   = krdoq_pkg::KIND_RELEASE;
      ost_nxt  = krdoq_pkg::STAT_OK;
      ohdl_nxt = rd_hdl_r;
      olen_nxt = rd_len_r;
      oseq_nxt = tail_r;
      okf_nxt  = rd_kf_r;
      ocur_nxt = cursor_r;
      olast_nxt = 1'b0;
    end
    if (cmd_i.ans_load) begin
      ok_nxt   = krdoq_pkg::KIND_ANSWER;
      ost_nxt  = cmd_i.ans_status;
      ohdl_nxt = show_unit ? rd_hdl_r : '0;
      olen_nxt = show_unit ? rd_len_r : '0;
      oseq_nxt = show_unit ? s_r : '0;
      okf_nxt  = show_unit ? rd_kf_r : 1'b0;
      ocur_nxt = (op_r == krdoq_pkg::OP_ADVANCE) ? next_r : cursor_r;
      olast_nxt = 1'b1;
    end

    if (clear_i) begin
      head_nxt = '0; tail_nxt = '0; head_slot_nxt = '0; tail_slot_nxt = '0;
      count_nxt = '0; retained_nxt = '0; drop_nxt = '0; push_nxt = '0;
      resync_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; head_slot_r <= '0; tail_slot_r <= '0;
      count_r <= '0; retained_r <= '0; drop_r <= '0; push_r <= '0;
      resync_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt; head_slot_r <= head_slot_nxt;
      tail_slot_r <= tail_slot_nxt; count_r <= count_nxt; retained_r <= retained_nxt;
      drop_r <= drop_nxt; push_r <= push_nxt; resync_r <= resync_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; hdl_r <= hdl_nxt; len_r <= len_nxt; kfin_r <= kfin_nxt;
    cursor_r <= cursor_nxt; acc_r <= acc_nxt;
    ptr_r <= ptr_nxt; n_r <= n_nxt; wcnt_r <= wcnt_nxt; rem_r <= rem_nxt; s_r <= s_nxt;
    next_r <= next_nxt; diff_r <= diff_nxt; dcond_r <= dcond_nxt; loc_ok_r <= loc_ok_nxt;
    ok_r <= ok_nxt; ost_r <= ost_nxt; ohdl_r <= ohdl_nxt; olen_r <= olen_nxt;
    oseq_r <= oseq_nxt; okf_r <= okf_nxt; ocur_r <= ocur_nxt; ohead_r <= ohead_nxt;
    odrop_r <= odrop_nxt; opush_r <= opush_nxt; olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.pu_write) begin
      mem_hdl[head_slot_r] <= hdl_r;
      mem_len[head_slot_r] <= len_r;
      mem_kf[head_slot_r]  <= kfin_r;
    end
    rd_hdl_r <= mem_hdl[ptr_r];
    rd_len_r <= mem_len[ptr_r];
    rd_kf_r  <= mem_kf[ptr_r];
  end

  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_status        = ost_r;
  assign out_unit_handle   = krdoq_pkg::HDL_W'(ohdl_r);
  assign out_unit_length   = olen_r;
  assign out_unit_sequence = oseq_r;
  assign out_unit_keyframe = okf_r;
  assign out_cursor_next   = ocur_r;
  assign out_head_count    = ohead_r;
  assign out_dropped_count = odrop_r;
  assign out_pushed_count  = opush_r;
  assign out_last          = olast_r;

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_i)
    else $error("live unit count above capacity");
  // a push bumps head at commit and the live count only when the slot is written
  a_count_span: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r - tail_r) == QW'(count_r)) ||
    ((op_r == krdoq_pkg::OP_PUSH) && ((head_r - tail_r) == QW'(count_r) + QW'(1))))
    else $error("live count disagrees with head and tail");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.rel_emit || cmd_i.ans_load) |-> out_free)
    else $error("result register overwritten while held");
`endif

endmodule
